### rtl/kcmm_pkg.sv
// kcmm_pkg: shared constants, operation and status codes for the key count
// min/max tracker. No dependencies; used by kcmm_cell, the core and the testbench.

package kcmm_pkg;

  localparam int KEY_W          = 6;
  localparam int KEYS_DEF       = 64;
  localparam int COUNT_BITS_DEF = 16;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_APPEND,
    OP_INC,
    OP_DEC,
    OP_REMOVE
  } op_t;

  typedef enum logic [1:0] {
    ST_DONE    = 2'd0,
    ST_IGNORED = 2'd1,
    ST_SAT     = 2'd2
  } status_t;

  typedef struct packed {
    op_t              op;
    logic [KEY_W-1:0] key;
    logic [KEY_W-1:0] probe;
  } cell_cmd_t;

endpackage

### rtl/kcmm_prefix.sv
// kcmm_prefix: log-depth parallel prefix OR, dout[i] = OR of din[0..i].
// Depends on nothing.

module kcmm_prefix #(
  parameter int N = 2
) (
  input  logic [N-1:0] din,
  output logic [N-1:0] dout
);

  localparam int L = (N > 1) ? $clog2(N) : 1;

  wire [N-1:0] lvl [L+1];

  assign lvl[0] = din;

  for (genvar l = 0; l < L; l++) begin : g_lvl
    for (genvar i = 0; i < N; i++) begin : g_bit
      if (i >= (1 << l)) begin : g_or
        assign lvl[l+1][i] = lvl[l][i] | lvl[l][i-(1<<l)];
      end else begin : g_pass
        assign lvl[l+1][i] = lvl[l][i];
      end
    end
  end

  assign dout = lvl[L];

endmodule

### rtl/kcmm_cell.sv
// kcmm_cell: one slot of the ordered key list (valid, key, count).
// Shifts from a neighbor or loads the request key. Uses kcmm_pkg.

module kcmm_cell #(
  parameter int COUNT_BITS = kcmm_pkg::COUNT_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  kcmm_pkg::cell_cmd_t          cmd,
  input  logic [COUNT_BITS-1:0]        old_cnt,
  input  logic [COUNT_BITS-1:0]        new_cnt,
  input  logic                         pre,
  input  logic                         suf,
  input  logic                         left_vld,
  input  logic                         left_run,
  input  logic [kcmm_pkg::KEY_W-1:0]   left_key,
  input  logic [COUNT_BITS-1:0]        left_cnt,
  input  logic                         right_vld,
  input  logic                         right_run,
  input  logic [kcmm_pkg::KEY_W-1:0]   right_key,
  input  logic [COUNT_BITS-1:0]        right_cnt,
  output logic                         vld,
  output logic                         run,
  output logic                         hit,
  output logic [kcmm_pkg::KEY_W-1:0]   key,
  output logic [COUNT_BITS-1:0]        cnt
);

  logic                       vld_r, vld_nxt;
  logic [kcmm_pkg::KEY_W-1:0] key_r, key_nxt;
  logic [COUNT_BITS-1:0]      cnt_r, cnt_nxt;

  assign run = vld_r && (cnt_r == old_cnt);
  assign hit = vld_r && (key_r == cmd.probe);
  assign vld = vld_r;
  assign key = key_r;
  assign cnt = cnt_r;

  always_comb begin
    vld_nxt = vld_r;
    key_nxt = key_r;
    cnt_nxt = cnt_r;
    unique case (cmd.op)
      kcmm_pkg::OP_APPEND: begin
        if (!vld_r && left_vld) begin
          vld_nxt = 1'b1;
          key_nxt = cmd.key;
          cnt_nxt = new_cnt;
        end
      end
      kcmm_pkg::OP_INC: begin
        if (run && pre) begin
          if (left_run) begin
            key_nxt = left_key;
            cnt_nxt = left_cnt;
          end else begin
            key_nxt = cmd.key;
            cnt_nxt = new_cnt;
          end
        end
      end
      kcmm_pkg::OP_DEC: begin
        if (run && suf) begin
          if (right_run) begin
            key_nxt = right_key;
            cnt_nxt = right_cnt;
          end else begin
            key_nxt = cmd.key;
            cnt_nxt = new_cnt;
          end
        end
      end
      kcmm_pkg::OP_REMOVE: begin
        if (suf) begin
          vld_nxt = right_vld;
          key_nxt = right_key;
          cnt_nxt = right_cnt;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    key_r <= key_nxt;
    cnt_r <= cnt_nxt;
  end

endmodule

### rtl/key_count_min_max_tracker_core.sv
// key_count_min_max_tracker_core: top level, chain of kcmm_cell slots plus
// per-key count memory. Depends on kcmm_pkg, kcmm_prefix, kcmm_cell.

// Each request is accepted and then applied: in the accept cycle every cell matches its
// key against in_key (prefix/suffix of the match is registered) and the
// key's count is read from the count memory; in the next cycle the whole cell
// chain shifts by at most one slot and the count memory is written. The
// result is shown with out_strobe, a one-cycle strobe in the cycle after that,
// during which busy is already low, so a new request may be accepted then. The
// result must be taken when out_strobe is high; it is not held.

module key_count_min_max_tracker_core #(
  parameter int KEYS       = kcmm_pkg::KEYS_DEF,
  parameter int COUNT_BITS = kcmm_pkg::COUNT_BITS_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  output logic                       busy,
  input  logic                       in_action,
  input  logic [kcmm_pkg::KEY_W-1:0] in_key,
  output logic                       out_strobe,
  output logic [kcmm_pkg::KEY_W-1:0] out_max_key,
  output logic [kcmm_pkg::KEY_W-1:0] out_min_key,
  output logic                       out_empty_res,
  output logic [1:0]                 out_status
);

  localparam int KEY_SPACE = 1 << kcmm_pkg::KEY_W;
  localparam int MEM_DEPTH = (KEYS < KEY_SPACE) ? KEYS : KEY_SPACE;
  localparam int IDX_W     = $clog2(MEM_DEPTH);

  logic                       accept;
  logic                       s1_vld_r;
  logic                       act_r;
  logic                       key_ok_r;
  logic [kcmm_pkg::KEY_W-1:0] key_r;
  logic [IDX_W-1:0]           idx_r;
  logic [COUNT_BITS-1:0]      rd_cnt_r;
  logic                       rd_vld_r;
  logic [KEYS-1:0]            pre_r, suf_r;
  logic                       out_strobe_r;
  kcmm_pkg::status_t          out_status_r;

  logic [COUNT_BITS-1:0]      count_mem [MEM_DEPTH];
  logic [MEM_DEPTH-1:0]       cnt_vld_r;

  wire  [KEYS-1:0]            cell_vld, cell_run, cell_hit;
  wire  [kcmm_pkg::KEY_W-1:0] cell_key [KEYS];
  wire  [COUNT_BITS-1:0]      cell_cnt [KEYS];
  wire  [KEYS-1:0]            hit_rev, pre_w, suf_w, pre_rev;
  wire  [KEYS-1:0]            tail;

  logic [COUNT_BITS-1:0]      old_cnt, new_cnt;
  kcmm_pkg::op_t              op;
  kcmm_pkg::status_t          stat;
  kcmm_pkg::cell_cmd_t        cmd;
  logic [kcmm_pkg::KEY_W-1:0] tail_key;

  assign accept = start && !s1_vld_r;
  assign busy   = s1_vld_r;

  // request decode
  always_comb begin
    old_cnt = rd_vld_r ? rd_cnt_r : '0;
    op      = kcmm_pkg::OP_NONE;
    stat    = kcmm_pkg::ST_DONE;
    new_cnt = old_cnt;
    priority if (!key_ok_r) begin
      stat = kcmm_pkg::ST_IGNORED;
    end else if (!act_r) begin
      priority if (old_cnt == '0) begin
        op      = kcmm_pkg::OP_APPEND;
        new_cnt = COUNT_BITS'(1);
      end else if (old_cnt == '1) begin
        stat = kcmm_pkg::ST_SAT;
      end else begin
        op      = kcmm_pkg::OP_INC;
        new_cnt = old_cnt + COUNT_BITS'(1);
      end
    end else begin
      priority if (old_cnt == '0) begin
        stat = kcmm_pkg::ST_IGNORED;
      end else if (old_cnt == COUNT_BITS'(1)) begin
        op = kcmm_pkg::OP_REMOVE;
      end else begin
        op      = kcmm_pkg::OP_DEC;
        new_cnt = old_cnt - COUNT_BITS'(1);
      end
    end
  end

  assign cmd.op    = s1_vld_r ? op : kcmm_pkg::OP_NONE;
  assign cmd.key   = key_r;
  assign cmd.probe = in_key;

  // cell chain
  for (genvar i = 0; i < KEYS; i++) begin : g_cell
    logic                       lv, lr, rv, rr;
    logic [kcmm_pkg::KEY_W-1:0] lk, rk;
    logic [COUNT_BITS-1:0]      lc, rc;

    if (i == 0) begin : g_head
      assign lv = 1'b1;
      assign lr = 1'b0;
      assign lk = '0;
      assign lc = '0;
    end else begin : g_left
      assign lv = cell_vld[i-1];
      assign lr = cell_run[i-1];
      assign lk = cell_key[i-1];
      assign lc = cell_cnt[i-1];
    end

    if (i == KEYS - 1) begin : g_last
      assign rv = 1'b0;
      assign rr = 1'b0;
      assign rk = '0;
      assign rc = '0;
      assign tail[i] = cell_vld[i];
    end else begin : g_right
      assign rv = cell_vld[i+1];
      assign rr = cell_run[i+1];
      assign rk = cell_key[i+1];
      assign rc = cell_cnt[i+1];
      assign tail[i] = cell_vld[i] & ~cell_vld[i+1];
    end

    kcmm_cell #(
      .COUNT_BITS (COUNT_BITS)
    ) u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .cmd       (cmd),
      .old_cnt   (old_cnt),
      .new_cnt   (new_cnt),
      .pre       (pre_r[i]),
      .suf       (suf_r[i]),
      .left_vld  (lv),
      .left_run  (lr),
      .left_key  (lk),
      .left_cnt  (lc),
      .right_vld (rv),
      .right_run (rr),
      .right_key (rk),
      .right_cnt (rc),
      .vld       (cell_vld[i]),
      .run       (cell_run[i]),
      .hit       (cell_hit[i]),
      .key       (cell_key[i]),
      .cnt       (cell_cnt[i])
    );

    assign hit_rev[i] = cell_hit[KEYS-1-i];
    assign pre_w[i]   = pre_rev[KEYS-1-i];
  end

  // suf: slots at or behind the hit, pre: slots from the head up to the hit
  kcmm_prefix #(.N(KEYS)) u_suf (.din(cell_hit), .dout(suf_w));
  kcmm_prefix #(.N(KEYS)) u_pre (.din(hit_rev),  .dout(pre_rev));

  // request capture
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r     <= 1'b0;
      out_strobe_r <= 1'b0;
    end else begin
      s1_vld_r     <= accept;
      out_strobe_r <= s1_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      act_r    <= in_action;
      key_r    <= in_key;
      key_ok_r <= 32'(in_key) < KEYS;
      idx_r    <= in_key[IDX_W-1:0];
      pre_r    <= pre_w;
      suf_r    <= suf_w;
    end
    if (s1_vld_r) begin
      out_status_r <= stat;
    end
  end

  // count memory
  always_ff @(posedge clk) begin
    if (accept) begin
      rd_cnt_r <= count_mem[in_key[IDX_W-1:0]];
    end
    if (s1_vld_r && op != kcmm_pkg::OP_NONE) begin
      count_mem[idx_r] <= new_cnt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_vld_r <= '0;
      rd_vld_r  <= 1'b0;
    end else begin
      if (accept) begin
        rd_vld_r <= cnt_vld_r[in_key[IDX_W-1:0]];
      end
      if (s1_vld_r && op != kcmm_pkg::OP_NONE) begin
        cnt_vld_r[idx_r] <= (op != kcmm_pkg::OP_REMOVE);
      end
    end
  end

  // list ends
  always_comb begin
    tail_key = '0;
    for (int i = 0; i < KEYS; i++) begin
      if (tail[i]) begin
        tail_key = tail_key | cell_key[i];
      end
    end
  end

  assign out_strobe    = out_strobe_r;
  assign out_max_key   = cell_vld[0] ? cell_key[0] : '0;
  assign out_min_key   = tail_key;
  assign out_empty_res = !cell_vld[0];
  assign out_status    = out_status_r;

  a_req_to_result: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> busy ##1 (out_strobe && !busy))
    else $error("request did not produce a result two cycles later");

  a_busy_one_cycle: assert property (@(posedge clk) disable iff (!rst_n)
    busy |=> !busy)
    else $error("update held longer than one cycle");

  a_list_contiguous: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(tail))
    else $error("occupied slots are not contiguous from the head");

  a_strobe_source: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> $past(busy))
    else $error("result strobe without an update");

endmodule

### tb/key_count_min_max_tracker_core_test.sv
// Self-checking testbench for key_count_min_max_tracker_core: directed table, random
// request mixes and a closing back-to-back burst, checked by a predictor or pinned results.
// Depends on kcmm_pkg and the RTL in rtl/.
`timescale 1ns / 100ps

module key_count_min_max_tracker_core_test;

  localparam int CYCLE_LIMIT  = 1_000_000;
  localparam int RANDOM_ITEMS = 480;
  localparam int TAIL_ITEMS   = 40;
  localparam int SWEEP_AT     = 220;
  localparam int KEY_W        = kcmm_pkg::KEY_W;
  localparam int KEYS_DEF     = kcmm_pkg::KEYS_DEF;
  localparam int CNT_W        = kcmm_pkg::COUNT_BITS_DEF;
  localparam logic ACT_INC = 1'b0;
  localparam logic ACT_DEC = 1'b1;
  localparam logic [CNT_W-1:0] COUNT_TOP = '1;

  typedef struct packed {
    logic [KEY_W-1:0]  max_key;
    logic [KEY_W-1:0]  min_key;
    logic              empty_res;
    kcmm_pkg::status_t status;
  } tracker_out_t;

  typedef struct {
    logic             act;
    logic [KEY_W-1:0] k;
    bit               pinned;
    tracker_out_t     res;
  } step_t;

  typedef enum logic [1:0] {MIX_GROW, MIX_SHRINK, MIX_CHURN} mix_t;

  logic             clk = 1'b0;
  logic             rst_n;
  logic             start;
  logic             busy;
  logic             in_action;
  logic [KEY_W-1:0] in_key;
  logic             out_strobe;
  logic [KEY_W-1:0] out_max_key;
  logic [KEY_W-1:0] out_min_key;
  logic             out_empty_res;
  logic [1:0]       out_status;

  // predictor state
  logic [CNT_W-1:0]  tally [KEYS_DEF];
  logic [KEY_W-1:0]  ranking [KEYS_DEF];
  int                n_present;

  tracker_out_t outstanding[$];
  step_t        steps[$];
  bit           pin_on;
  tracker_out_t pin_res;
  bit           quiet;

  int errors;
  int cycles;
  int n_checked;
  int n_sat;
  int n_ignored;
  int n_empty;
  int peak;

  key_count_min_max_tracker_core u_top (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .in_action    (in_action),
    .in_key       (in_key),
    .out_strobe   (out_strobe),
    .out_max_key  (out_max_key),
    .out_min_key  (out_min_key),
    .out_empty_res(out_empty_res),
    .out_status   (out_status)
  );

  always #5 clk = ~clk;

  task automatic report(string msg);
    $display("MISMATCH @%0t: %s", $realtime, msg);
    errors++;
  endtask

  function automatic void settle(int pos);
    logic [CNT_W-1:0] c;
    logic [KEY_W-1:0] t;
    c = tally[ranking[pos]];
    while (pos > 0 && tally[ranking[pos-1]] < c) begin
      t = ranking[pos];
      ranking[pos] = ranking[pos-1];
      ranking[pos-1] = t;
      pos--;
    end
    while (pos + 1 < n_present && tally[ranking[pos+1]] > c) begin
      t = ranking[pos];
      ranking[pos] = ranking[pos+1];
      ranking[pos+1] = t;
      pos++;
    end
  endfunction

  function automatic tracker_out_t apply_request(logic act, logic [KEY_W-1:0] k);
    tracker_out_t r;
    int pos;
    int i;
    r.status = kcmm_pkg::ST_DONE;
    pos = 0;
    for (i = n_present - 1; i >= 0; i--)
      if (ranking[i] == k) pos = i;
    if (act == ACT_INC) begin
      if (tally[k] == 0) begin
        tally[k] = 1;
        ranking[n_present] = k;
        n_present++;
      end else if (tally[k] == COUNT_TOP) begin
        r.status = kcmm_pkg::ST_SAT;
      end else begin
        tally[k]++;
        settle(pos);
      end
    end else if (tally[k] == 0) begin
      r.status = kcmm_pkg::ST_IGNORED;
    end else begin
      tally[k]--;
      if (tally[k] == 0) begin
        for (i = pos; i + 1 < n_present; i++) ranking[i] = ranking[i+1];
        n_present--;
      end else begin
        settle(pos);
      end
    end
    r.empty_res = (n_present == 0);
    r.max_key   = r.empty_res ? '0 : ranking[0];
    r.min_key   = r.empty_res ? '0 : ranking[n_present-1];
    return r;
  endfunction

  // checker: results first, then the request accepted at this edge
  always @(posedge clk) begin
    tracker_out_t want;
    if (rst_n) begin
      if (out_strobe) begin
        if (outstanding.size() == 0) begin
          report("result strobe with no request outstanding");
        end else begin
          want = outstanding.pop_front();
          if (out_max_key !== want.max_key)
            report($sformatf("result %0d: max_key %0d, want %0d",
                             n_checked, out_max_key, want.max_key));
          if (out_min_key !== want.min_key)
            report($sformatf("result %0d: min_key %0d, want %0d",
                             n_checked, out_min_key, want.min_key));
          if (out_empty_res !== want.empty_res)
            report($sformatf("result %0d: empty_res %b, want %b",
                             n_checked, out_empty_res, want.empty_res));
          if (out_status !== want.status)
            report($sformatf("result %0d: status %0d, want %s",
                             n_checked, out_status, want.status.name()));
          n_checked++;
        end
      end
      if (start && !busy) begin
        want = apply_request(in_action, in_key);
        if (want.status == kcmm_pkg::ST_SAT) n_sat++;
        if (want.status == kcmm_pkg::ST_IGNORED) n_ignored++;
        if (want.empty_res) n_empty++;
        if (n_present > peak) peak = n_present;
        if (pin_on) want = pin_res;
        outstanding.push_back(want);
      end
    end
  end

  initial begin
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("Timeout after %0d cycles, %0d results outstanding", cycles, outstanding.size());
    $display("Regression FAIL");
    $finish;
  end

  task automatic pause(int n);
    repeat (n) begin
      @(negedge clk);
      start     <= 1'b0;
      in_action <= 1'($urandom);
      in_key    <= KEY_W'($urandom);
    end
  endtask

  task automatic maybe_pause();
    if (!quiet && $urandom_range(0, 3) == 0) pause($urandom_range(1, 5));
  endtask

  task automatic issue(logic act, logic [KEY_W-1:0] k, bit pinned, tracker_out_t res);
    @(negedge clk);
    start     <= 1'b1;
    in_action <= act;
    in_key    <= k;
    pin_on  = pinned;
    pin_res = res;
    do @(posedge clk); while (busy);
  endtask

  task automatic add_step(logic act, logic [KEY_W-1:0] k, bit pinned, tracker_out_t res);
    step_t s;
    s.act = act;
    s.k = k;
    s.pinned = pinned;
    s.res = res;
    steps.push_back(s);
  endtask

  initial begin
    step_t            s;
    mix_t             mix;
    int               n_issued;
    int               span;
    int               base;
    int               i;
    int               j;
    int               tmp;
    int               perm[KEYS_DEF];
    bit               swept;
    logic             act;
    logic [KEY_W-1:0] k;

    rst_n     = 1'b0;
    start     = 1'b0;
    in_action = 1'b0;
    in_key    = '0;
    pin_on    = 1'b0;
    pin_res   = '0;
    quiet     = 1'b0;
    n_present = 0;
    for (i = 0; i < KEYS_DEF; i++) begin
      tally[i]   = '0;
      ranking[i] = '0;
    end
    repeat (2) @(negedge clk);
    rst_n <= 1'b1;

    // directed table; typed results only where obvious
    add_step(ACT_DEC, 6'd0,  1'b1, tracker_out_t'{6'd0, 6'd0, 1'b1, kcmm_pkg::ST_IGNORED});
    add_step(ACT_INC, 6'd63, 1'b1, tracker_out_t'{6'd63, 6'd63, 1'b0, kcmm_pkg::ST_DONE});
    add_step(ACT_INC, 6'd0,  1'b1, tracker_out_t'{6'd63, 6'd0, 1'b0, kcmm_pkg::ST_DONE});
    add_step(ACT_INC, 6'd0,  1'b0, '0);
    add_step(ACT_INC, 6'd42, 1'b0, '0);
    add_step(ACT_INC, 6'd42, 1'b0, '0);
    add_step(ACT_INC, 6'd42, 1'b0, '0);
    add_step(ACT_DEC, 6'd42, 1'b0, '0);
    add_step(ACT_DEC, 6'd63, 1'b0, '0);
    add_step(ACT_DEC, 6'd63, 1'b0, '0);
    add_step(ACT_INC, 6'd21, 1'b0, '0);
    add_step(ACT_DEC, 6'd42, 1'b0, '0);
    add_step(ACT_DEC, 6'd0,  1'b0, '0);
    add_step(ACT_INC, 6'd1,  1'b0, '0);
    add_step(ACT_DEC, 6'd42, 1'b0, '0);
    add_step(ACT_DEC, 6'd0,  1'b0, '0);
    add_step(ACT_DEC, 6'd1,  1'b0, '0);
    add_step(ACT_DEC, 6'd21, 1'b1, tracker_out_t'{6'd0, 6'd0, 1'b1, kcmm_pkg::ST_DONE});
    add_step(ACT_DEC, 6'd21, 1'b1, tracker_out_t'{6'd0, 6'd0, 1'b1, kcmm_pkg::ST_IGNORED});
    add_step(ACT_INC, 6'd62, 1'b0, '0);
    add_step(ACT_INC, 6'd63, 1'b0, '0);
    add_step(ACT_INC, 6'd63, 1'b0, '0);
    add_step(ACT_DEC, 6'd62, 1'b0, '0);
    foreach (steps[i]) begin
      s = steps[i];
      maybe_pause();
      issue(s.act, s.k, s.pinned, s.res);
    end

    // random mixes; one full sweep of every key and a drain to empty midway
    n_issued = 0;
    swept = 1'b0;
    while (n_issued < RANDOM_ITEMS) begin
      if (!swept && n_issued >= SWEEP_AT) begin
        swept = 1'b1;
        for (i = 0; i < KEYS_DEF; i++) perm[i] = i;
        for (i = KEYS_DEF - 1; i > 0; i--) begin
          j = $urandom_range(0, i);
          tmp = perm[i];
          perm[i] = perm[j];
          perm[j] = tmp;
        end
        for (i = 0; i < KEYS_DEF; i++) begin
          maybe_pause();
          issue(ACT_INC, KEY_W'(perm[i]), 1'b0, '0);
          n_issued++;
        end
        while (n_present > 0) begin
          maybe_pause();
          issue(ACT_DEC, ranking[$urandom_range(0, n_present - 1)], 1'b0, '0);
          n_issued++;
        end
      end
      mix   = mix_t'($urandom_range(0, 2));
      span  = $urandom_range(30, 60);
      base  = $urandom_range(0, KEYS_DEF - 4);
      quiet = ($urandom_range(0, 3) == 0);
      repeat (span) begin
        act = 1'($urandom);
        k   = KEY_W'($urandom);
        case (mix)
          MIX_GROW: begin
            act = ($urandom_range(0, 3) != 0) ? ACT_INC : ACT_DEC;
            if ($urandom_range(0, 1) == 0) k = KEY_W'(base + $urandom_range(0, 3));
          end
          MIX_SHRINK: begin
            if (n_present > 0 && $urandom_range(0, 4) != 0) begin
              act = ACT_DEC;
              k   = ranking[$urandom_range(0, n_present - 1)];
            end
          end
          default: begin
            k = KEY_W'(base + $urandom_range(0, 3));
          end
        endcase
        n_issued++;
        maybe_pause();
        issue(act, k, 1'b0, '0);
      end
    end

    // closing burst on a few keys, back to back with no idle cycles
    quiet = 1'b1;
    base  = $urandom_range(0, KEYS_DEF - 4);
    repeat (TAIL_ITEMS) begin
      act = ($urandom_range(0, 2) != 0) ? ACT_INC : ACT_DEC;
      k   = KEY_W'(base + $urandom_range(0, 3));
      issue(act, k, 1'b0, '0);
    end

    @(negedge clk);
    start <= 1'b0;
    while (outstanding.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (outstanding.size() != 0)
      report($sformatf("%0d results never arrived", outstanding.size()));

    $display("Checked %0d results: %0d saturated, %0d ignored, %0d with empty list",
             n_checked, n_sat, n_ignored, n_empty);
    $display("Longest key list %0d of %0d, %0d mismatches", peak, KEYS_DEF, errors);
    if (errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

### filelist.f
rtl/kcmm_pkg.sv
rtl/kcmm_prefix.sv
rtl/kcmm_cell.sv
rtl/key_count_min_max_tracker_core.sv
tb/key_count_min_max_tracker_core_test.sv
